// ----- src/acr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache responder package
// Shared constants, result codes and the token that walks the cell chain.
// ----------------------------------------------------------------------------
package acr_pkg;

    localparam int DEF_TABLE_ENTRIES = 16;

    localparam int IP_W       = 32;
    localparam int MAC_W      = 48;
    localparam int FLEN_W     = 11;
    localparam int OPER_W     = 16;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 48;

    localparam logic [FLEN_W-1:0]    MIN_FRAME_BYTES = 11'd42;
    localparam logic [OPER_W-1:0]    OP_REQUEST      = 16'd1;
    localparam logic                 OPC_PACKET      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP      = 8'd0;

    localparam logic [KIND_W-1:0] KIND_HIT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MISS  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REPLY = 2'd2;

    localparam logic [1:0] MODE_SEARCH    = 2'd0;
    localparam logic [1:0] MODE_UPDATE    = 2'd1;
    localparam logic [1:0] MODE_FILL      = 2'd2;
    localparam logic [1:0] MODE_OVERWRITE = 2'd3;

    typedef struct packed {
        logic             act;
        logic [1:0]       mode;
        logic [IP_W-1:0]  key;
        logic [MAC_W-1:0] mac;
        logic             taken;
        logic             free;
    } t_tok;

endpackage

// ----- src/acr_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache cell
// Holds one table entry; checks or writes it as the token passes by.
// ----------------------------------------------------------------------------
module acr_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  acr_pkg::t_tok i_tok,
    output acr_pkg::t_tok o_tok
);

    logic                      r_valid;
    logic [acr_pkg::IP_W-1:0]  r_ip;
    logic [acr_pkg::MAC_W-1:0] r_mac;
    acr_pkg::t_tok             r_tok;
    acr_pkg::t_tok             n_tok;
    logic                      w_match;
    logic                      w_wr;

    assign w_match = r_valid && (r_ip == i_tok.key);

    always_comb begin
        n_tok = i_tok;
        w_wr  = 1'b0;
        if (i_tok.act) begin
            case (i_tok.mode)
                acr_pkg::MODE_SEARCH: begin
                    if (w_match && !i_tok.taken) begin
                        n_tok.taken = 1'b1;
                        n_tok.mac   = r_mac;
                    end
                    if (!r_valid) begin
                        n_tok.free = 1'b1;
                    end
                end
                acr_pkg::MODE_UPDATE: begin
                    if (w_match && !i_tok.taken) begin
                        w_wr        = 1'b1;
                        n_tok.taken = 1'b1;
                    end
                end
                acr_pkg::MODE_FILL: begin
                    if (!r_valid && !i_tok.taken) begin
                        w_wr        = 1'b1;
                        n_tok.taken = 1'b1;
                    end
                end
                acr_pkg::MODE_OVERWRITE: begin
                    if (!i_tok.taken) begin
                        w_wr        = 1'b1;
                        n_tok.taken = 1'b1;
                    end
                end
                default: begin
                    n_tok = i_tok;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        if (!i_rst_n) begin
            r_tok.act <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_wr) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_ip  <= i_tok.key;
            r_mac <= i_tok.mac;
        end
    end

    assign o_tok = r_tok;

endmodule

// ----- src/arp_cache_responder.sv -----
`timescale 1ns / 1ps
// Lookup: search pass, then the result is loaded into the output register once it is free;
// ready returns as the result is loaded. Learning packet: search pass, then write pass;
// with a reply the reply is loaded after the write pass, else ready returns after it.
// Short packet or zero sender without reply: next accept in the cycle after accept;
// zero sender with reply: the reply is loaded with no pass. One transaction at a time.
// Synchronous active-low reset clears all entry valid marks and own_ip.
// ----------------------------------------------------------------------------
// ARP cache responder
// Learns sender address pairs into a chain of cells and answers lookups and
// requests aimed at our own address.
// ----------------------------------------------------------------------------
module arp_cache_responder #(
    parameter int TABLE_ENTRIES = acr_pkg::DEF_TABLE_ENTRIES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_opcode,
    input  logic [acr_pkg::FLEN_W-1:0]     i_frame_length,
    input  logic [acr_pkg::OPER_W-1:0]     i_arp_operation,
    input  logic [acr_pkg::IP_W-1:0]       i_sender_ip,
    input  logic [acr_pkg::MAC_W-1:0]      i_sender_mac,
    input  logic [acr_pkg::IP_W-1:0]       i_tgt_ip,
    input  logic [acr_pkg::IP_W-1:0]       i_query_ip,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [acr_pkg::KIND_W-1:0]     o_result_kind,
    output logic [acr_pkg::MAC_W-1:0]      o_peer_mac,
    output logic [acr_pkg::IP_W-1:0]       o_peer_ip,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [acr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [acr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_WRITE  = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0]                 r_state;
    logic [1:0]                 n_state;
    logic                       r_lookup;
    logic [acr_pkg::IP_W-1:0]   r_key;
    logic [acr_pkg::MAC_W-1:0]  r_mac;
    logic                       r_reply;
    logic                       r_hit;
    logic [acr_pkg::MAC_W-1:0]  r_hit_mac;
    logic [acr_pkg::IP_W-1:0]   r_own_ip;
    acr_pkg::t_tok              r_head;
    acr_pkg::t_tok              n_head;
    logic                       r_out_valid;
    logic [acr_pkg::KIND_W-1:0] r_out_kind;
    logic [acr_pkg::MAC_W-1:0]  r_out_mac;
    logic [acr_pkg::IP_W-1:0]   r_out_ip;

    acr_pkg::t_tok              w_tok [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES:0]     w_act;
    acr_pkg::t_tok              w_tail;
    logic                       w_accept;
    logic                       w_pkt_ok;
    logic                       w_pkt_reply;
    logic                       w_load_out;
    logic                       w_latch_hit;

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && o_ready;
    assign w_pkt_ok    = (i_opcode == acr_pkg::OPC_PACKET)
                         && (i_frame_length >= acr_pkg::MIN_FRAME_BYTES);
    assign w_pkt_reply = (i_arp_operation == acr_pkg::OP_REQUEST)
                         && (i_tgt_ip == r_own_ip);
    assign w_load_out  = (r_state == ST_DONE) && (!r_out_valid || i_ready);

    assign w_tok[0] = r_head;
    assign w_tail   = w_tok[TABLE_ENTRIES];

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            acr_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_tok   (w_tok[g]),
                .o_tok   (w_tok[g+1])
            );
        end
        for (g = 0; g <= TABLE_ENTRIES; g++) begin : g_act
            assign w_act[g] = w_tok[g].act;
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_head.act  = 1'b0;
        w_latch_hit = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_opcode != acr_pkg::OPC_PACKET) begin
                        n_head.act   = 1'b1;
                        n_head.mode  = acr_pkg::MODE_SEARCH;
                        n_head.key   = i_query_ip;
                        n_head.mac   = '0;
                        n_head.taken = 1'b0;
                        n_head.free  = 1'b0;
                        n_state      = ST_SEARCH;
                    end else if (w_pkt_ok && (i_sender_ip != '0)) begin
                        n_head.act   = 1'b1;
                        n_head.mode  = acr_pkg::MODE_SEARCH;
                        n_head.key   = i_sender_ip;
                        n_head.mac   = '0;
                        n_head.taken = 1'b0;
                        n_head.free  = 1'b0;
                        n_state      = ST_SEARCH;
                    end else if (w_pkt_ok && w_pkt_reply) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SEARCH: begin
                if (w_tail.act) begin
                    if (r_lookup) begin
                        w_latch_hit = 1'b1;
                        n_state     = ST_DONE;
                    end else begin
                        n_head.act   = 1'b1;
                        n_head.key   = r_key;
                        n_head.mac   = r_mac;
                        n_head.taken = 1'b0;
                        n_head.free  = 1'b0;
                        if (w_tail.taken) begin
                            n_head.mode = acr_pkg::MODE_UPDATE;
                        end else if (w_tail.free) begin
                            n_head.mode = acr_pkg::MODE_FILL;
                        end else begin
                            n_head.mode = acr_pkg::MODE_OVERWRITE;
                        end
                        n_state = ST_WRITE;
                    end
                end
            end
            ST_WRITE: begin
                if (w_tail.act) begin
                    n_state = r_reply ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        if (!i_rst_n) begin
            r_head.act <= 1'b0;
        end
    end

    // hold the transaction fields while the token walks the chain
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_lookup <= (i_opcode != acr_pkg::OPC_PACKET);
            r_key    <= (i_opcode != acr_pkg::OPC_PACKET) ? i_query_ip : i_sender_ip;
            r_mac    <= i_sender_mac;
            r_reply  <= w_pkt_reply;
        end
        if (w_latch_hit) begin
            r_hit     <= w_tail.taken;
            r_hit_mac <= w_tail.mac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip <= '0;
        end else if (i_cfg_valid && o_cfg_ready && (i_cfg_index == acr_pkg::REG_OWN_IP)) begin
            r_own_ip <= i_cfg_data[acr_pkg::IP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_ip <= r_key;
            if (!r_lookup) begin
                r_out_kind <= acr_pkg::KIND_REPLY;
                r_out_mac  <= r_mac;
            end else if (r_hit) begin
                r_out_kind <= acr_pkg::KIND_HIT;
                r_out_mac  <= r_hit_mac;
            end else begin
                r_out_kind <= acr_pkg::KIND_MISS;
                r_out_mac  <= '0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_peer_mac    = r_out_mac;
    assign o_peer_ip     = r_out_ip;

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_act) <= 1)
        else $error("more than one token in the cell chain");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (w_act == '0))
        else $error("token in flight while accepting a transaction");

    a_tail_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.act |-> (r_state == ST_SEARCH || r_state == ST_WRITE))
        else $error("token left the chain outside a scan");

    a_done_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> (o_valid && o_ready))
        else $error("result load did not present a result");

endmodule
